// ===== sv/aag_pkg.sv =====
package aag_pkg;

	localparam int AAG_NUM_CHANNELS = 8;
	localparam int AAG_QUEUE_DEPTH  = 16;

	localparam logic [2:0]  GAIN_WIDEST = 3'd7;
	localparam logic [15:0] FS_WIDE     = 16'h7fff;
	localparam logic [15:0] FS_NARROW   = 16'h7ff0;
	localparam logic [15:0] CODE_MIN    = 16'h8000;

	// full scale is 256000 uV times a per-gain factor
	// positive: x * 16000 / 2047, negative: x * 125 / 16, with x = |code| * factor
	localparam logic [10:0] DIV_2047   = 11'd2047;
	localparam logic [20:0] RECIP_2047 = 21'd1049088;	// floor(2^31 / 2047)
	localparam logic [13:0] POS_SCALE  = 14'd16000;
	localparam logic [6:0]  NEG_SCALE  = 7'd125;

	typedef struct packed {
		logic        func;
		logic [15:0] sample_bytes;
	} cmd_t;

	typedef struct packed {
		logic [2:0]         set_channel;
		logic [2:0]         set_gain;
		logic               conversion_wanted;
		logic               reading_valid;
		logic [2:0]         reading_channel;
		logic [2:0]         reading_gain;
		logic signed [15:0] reading_code;
		logic signed [23:0] reading_microvolts;
		logic               wide_converter;
		logic               sweep_done;
	} res_t;

	// decided result plus operands for the voltage scaler
	typedef struct packed {
		res_t        res;
		logic [15:0] mag;
		logic [4:0]  mult;
		logic        neg;
	} s1_t;

	function automatic logic [4:0] gain_mult(input logic [2:0] gain);
		logic [4:0] m;
		case (gain)
			3'd0:    m = 5'd24;
			3'd1:    m = 5'd16;
			3'd2:    m = 5'd8;
			3'd3:    m = 5'd4;
			3'd4:    m = 5'd2;
			default: m = 5'd1;
		endcase
		return m;
	endfunction

endpackage

// ===== sv/aag_ctrl.sv =====
module aag_ctrl
	import aag_pkg::*;
#(
	parameter int NUM_CHANNELS = AAG_NUM_CHANNELS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic take,
	input  cmd_t cmd,
	output logic s1_valid,
	output s1_t  s1
);

	localparam logic [2:0] LAST_CH = 3'(NUM_CHANNELS - 1);

	logic [2:0]  chan_q, gain_q;
	logic        seen_q, active_q;
	logic [2:0]  chan_d, gain_d;
	logic        seen_d, active_d, seen_upd;
	logic [15:0] raw, limit;
	logic        over;
	s1_t         nxt;
	logic        valid_s1;
	s1_t         data_s1;

	always_comb begin
		raw      = {cmd.sample_bytes[7:0], cmd.sample_bytes[15:8]};
		seen_upd = seen_q | (raw[3:0] != 4'd0);
		limit    = seen_upd ? FS_WIDE : FS_NARROW;
		over     = (raw == limit) || (raw == CODE_MIN);

		chan_d   = chan_q;
		gain_d   = gain_q;
		seen_d   = seen_q;
		active_d = active_q;

		nxt                 = '0;
		nxt.res.set_channel = chan_q;
		nxt.res.set_gain    = gain_q;

		if (!cmd.func) begin
			chan_d   = '0;
			gain_d   = GAIN_WIDEST;
			active_d = 1'b1;
			nxt.res.set_channel       = '0;
			nxt.res.set_gain          = GAIN_WIDEST;
			nxt.res.conversion_wanted = 1'b1;
		end else if (active_q) begin
			seen_d = seen_upd;
			if (over && gain_q != 3'd0) begin
				// overrange: retry same channel one step down
				gain_d = gain_q - 3'd1;
				nxt.res.set_gain          = gain_d;
				nxt.res.conversion_wanted = 1'b1;
			end else begin
				nxt.res.reading_valid   = 1'b1;
				nxt.res.reading_channel = chan_q;
				nxt.res.reading_gain    = gain_q;
				nxt.res.reading_code    = signed'(raw);
				nxt.neg  = raw[15];
				nxt.mag  = raw[15] ? (~raw + 16'd1) : raw;
				nxt.mult = gain_mult(gain_q);
				gain_d   = GAIN_WIDEST;
				nxt.res.set_gain = GAIN_WIDEST;
				if (chan_q == LAST_CH) begin
					chan_d   = '0;
					active_d = 1'b0;
					nxt.res.set_channel = '0;
					nxt.res.sweep_done  = 1'b1;
				end else begin
					chan_d = chan_q + 3'd1;
					nxt.res.set_channel       = chan_d;
					nxt.res.conversion_wanted = 1'b1;
				end
			end
		end
		nxt.res.wide_converter = seen_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q   <= '0;
			gain_q   <= GAIN_WIDEST;
			seen_q   <= 1'b0;
			active_q <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take;
			if (take) begin
				chan_q   <= chan_d;
				gain_q   <= gain_d;
				seen_q   <= seen_d;
				active_q <= active_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			data_s1 <= nxt;
		end
	end

	assign s1_valid = valid_s1;
	assign s1       = data_s1;

	a_idle_home: assert property (@(posedge clk) disable iff (!arst_n)
		!active_q |-> (chan_q == 3'd0 && gain_q == GAIN_WIDEST))
		else $error("idle sweep state not at channel 0, widest gain");

	a_flag_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q |=> seen_q)
		else $error("16-bit converter flag cleared without reset");

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !cmd.func) |=> (active_q && chan_q == 3'd0 && gain_q == GAIN_WIDEST))
		else $error("start did not restart the sweep");

endmodule

// ===== sv/aag_scale.sv =====
module aag_scale
	import aag_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic s1_valid,
	input  s1_t  s1,
	output logic done_valid,
	output res_t done
);

	logic [8:2]  v_s;

	res_t        res_s2, res_s3, res_s4, res_s5, res_s6, res_s7, res_s8;
	logic        neg_s2, neg_s3, neg_s4, neg_s5, neg_s6, neg_s7, neg_s8;
	logic [19:0] x_s2, x_s3;
	logic [8:0]  qe_s3, qe_s4, q_s5;
	logic [22:0] nm_s3, nm_s4, nm_s5, nm_s6, nm_s7, nm_s8;
	logic [11:0] r0_s4, rr_s8;
	logic [10:0] r_s5;
	logic [24:0] t_s6, t_s7;
	logic [22:0] qk_s6, qk_s7, qk_s8;
	logic [13:0] te_s7, te_s8;

	logic [20:0] xp;
	logic [40:0] qp;
	logic [26:0] np;
	logic [19:0] r0w;
	logic        ge5;
	logic [45:0] tp;
	logic [24:0] rrw;
	logic [13:0] tt;
	logic [22:0] mag;
	logic signed [23:0] uv;

	always_comb begin
		xp  = 21'(s1.mag) * 21'(s1.mult);
		qp  = 41'(x_s2) * 41'(RECIP_2047);
		np  = 27'(x_s2) * 27'(NEG_SCALE);
		r0w = x_s3 - 20'(qe_s3) * 20'(DIV_2047);
		ge5 = r0_s4 >= 12'(DIV_2047);
		tp  = 46'(t_s6) * 46'(RECIP_2047);
		rrw = t_s7 - 25'(te_s7) * 25'(DIV_2047);
		// reciprocal estimate is low by at most one
		tt  = te_s8 + 14'(rr_s8 >= 12'(DIV_2047));
		mag = neg_s8 ? nm_s8 : (qk_s8 + 23'(tt));
		uv  = neg_s8 ? -signed'({1'b0, mag}) : signed'({1'b0, mag});
		done = res_s8;
		done.reading_microvolts = uv;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			v_s <= {v_s[7:2], s1_valid};
		end
	end

	always_ff @(posedge clk) begin
		res_s2 <= s1.res;
		neg_s2 <= s1.neg;
		x_s2   <= xp[19:0];

		res_s3 <= res_s2;
		neg_s3 <= neg_s2;
		x_s3   <= x_s2;
		qe_s3  <= qp[39:31];
		nm_s3  <= np[26:4];

		res_s4 <= res_s3;
		neg_s4 <= neg_s3;
		qe_s4  <= qe_s3;
		nm_s4  <= nm_s3;
		r0_s4  <= r0w[11:0];

		res_s5 <= res_s4;
		neg_s5 <= neg_s4;
		nm_s5  <= nm_s4;
		q_s5   <= qe_s4 + 9'(ge5);
		r_s5   <= ge5 ? 11'(r0_s4 - 12'(DIV_2047)) : r0_s4[10:0];

		res_s6 <= res_s5;
		neg_s6 <= neg_s5;
		nm_s6  <= nm_s5;
		t_s6   <= 25'(r_s5) * 25'(POS_SCALE);
		qk_s6  <= 23'(q_s5) * 23'(POS_SCALE);

		res_s7 <= res_s6;
		neg_s7 <= neg_s6;
		nm_s7  <= nm_s6;
		t_s7   <= t_s6;
		qk_s7  <= qk_s6;
		te_s7  <= tp[44:31];

		res_s8 <= res_s7;
		neg_s8 <= neg_s7;
		nm_s8  <= nm_s7;
		qk_s8  <= qk_s7;
		te_s8  <= te_s7;
		rr_s8  <= rrw[11:0];
	end

	assign done_valid = v_s[8];

endmodule

// ===== sv/aag_fifo.sv =====
module aag_fifo
	import aag_pkg::*;
#(
	parameter int DEPTH = AAG_QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  res_t wr_data,
	output logic rd_valid,
	input  logic rd_stall,
	output res_t rd_data
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	res_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          pop;

	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign pop      = rd_valid && !rd_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (wr_en && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !wr_en) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> ((count_q != CW'(DEPTH)) || pop))
		else $error("result queue overflow");

	a_ptr_track: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("empty queue with mismatched pointers");

endmodule

// ===== sv/adc_autorange_gain_sweep.sv =====
// channel | valid     | stall     | payload
// cmd     | cmd_valid | cmd_stall | cmd (cmd_t: func, sample_bytes)
// res     | res_valid | res_stall | res (res_t: settings, reading, flags)
//
// One item per cycle while cmd_stall is low; each result passes the input register,
// the voltage scaler's seven register stages and the result queue before it is offered.
// Up to QUEUE_DEPTH items may be in flight; cmd_stall rises when all credits are used.
// cmd_stall comes from a register only; res_stall reaches the command side only through credit_q.
// arst_n clears sweep state (channel 0, gain 7, 16-bit flag clear) and empties the queue.
module adc_autorange_gain_sweep
	import aag_pkg::*;
#(
	parameter int NUM_CHANNELS = AAG_NUM_CHANNELS,
	parameter int QUEUE_DEPTH  = AAG_QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  cmd_t cmd,
	output logic res_valid,
	input  logic res_stall,
	output res_t res
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic          take, give;
	logic          s1_valid, done_valid;
	s1_t           s1;
	res_t          done;
	logic [CW-1:0] credit_q;

	assign cmd_stall = (credit_q == CW'(QUEUE_DEPTH));
	assign take      = cmd_valid && !cmd_stall;
	assign give      = res_valid && !res_stall;

	// items in flight: input register, scaler stages plus queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else if (take && !give) begin
			credit_q <= credit_q + CW'(1);
		end else if (give && !take) begin
			credit_q <= credit_q - CW'(1);
		end
	end

	aag_ctrl #(
		.NUM_CHANNELS(NUM_CHANNELS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.cmd     (cmd),
		.s1_valid(s1_valid),
		.s1      (s1)
	);

	aag_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.s1_valid  (s1_valid),
		.s1        (s1),
		.done_valid(done_valid),
		.done      (done)
	);

	aag_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (done_valid),
		.wr_data (done),
		.rd_valid(res_valid),
		.rd_stall(res_stall),
		.rd_data (res)
	);

	a_credit_cover: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid || done_valid || s1_valid) |-> (credit_q != '0))
		else $error("result in flight without a credit");

endmodule

// ===== tb/sv/adc_autorange_gain_sweep_tb.sv =====
module adc_autorange_gain_sweep_tb;
	import aag_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int         NUM_CHANNELS = AAG_NUM_CHANNELS;
	localparam logic       FUNC_START   = 1'b0;
	localparam logic       FUNC_CONVERT = 1'b1;
	localparam int         RANDOM_ITEMS = 500;
	localparam int         DRAIN_CYCLES = 20;

	// tracks the sweep state and holds the results the block still owes
	class autorange_tracker;
		logic [2:0] chan;
		logic [2:0] gain;
		logic       wide;
		logic       active;
		res_t       awaited_res[$];
		int         errors;

		function new();
			chan = '0;
			gain = GAIN_WIDEST;
			wide = 1'b0;
			active = 1'b0;
			errors = 0;
		endfunction

		function longint microvolts(logic signed [15:0] code, logic [2:0] g);
			longint fs;
			longint p;
			case (g)
				3'd0:    fs = 6144000;
				3'd1:    fs = 4096000;
				3'd2:    fs = 2048000;
				3'd3:    fs = 1024000;
				3'd4:    fs = 512000;
				default: fs = 256000;
			endcase
			p = longint'(code) * fs;
			// SV division truncates toward zero
			return (code < 0) ? p / 32768 : p / 32752;
		endfunction

		function void take_cmd(cmd_t c);
			res_t        r;
			logic [15:0] raw;
			longint      uv;
			r = '0;
			if (c.func == FUNC_START) begin
				chan = '0;
				gain = GAIN_WIDEST;
				active = 1'b1;
				r.set_channel = '0;
				r.set_gain = GAIN_WIDEST;
				r.conversion_wanted = 1'b1;
			end else if (!active) begin
				r.set_channel = chan;
				r.set_gain = gain;
			end else begin
				raw = {c.sample_bytes[7:0], c.sample_bytes[15:8]};
				if (raw[3:0] != 4'h0)
					wide = 1'b1;
				if ((raw == (wide ? FS_WIDE : FS_NARROW) || raw == CODE_MIN) && gain != 3'd0) begin
					gain = gain - 3'd1;
					r.set_channel = chan;
					r.set_gain = gain;
					r.conversion_wanted = 1'b1;
				end else begin
					uv = microvolts(raw, gain);
					r.reading_valid = 1'b1;
					r.reading_channel = chan;
					r.reading_gain = gain;
					r.reading_code = raw;
					r.reading_microvolts = uv[23:0];
					if (int'(chan) == NUM_CHANNELS - 1) begin
						chan = '0;
						gain = GAIN_WIDEST;
						active = 1'b0;
						r.set_channel = '0;
						r.set_gain = GAIN_WIDEST;
						r.sweep_done = 1'b1;
					end else begin
						chan = chan + 3'd1;
						gain = GAIN_WIDEST;
						r.set_channel = chan;
						r.set_gain = GAIN_WIDEST;
						r.conversion_wanted = 1'b1;
					end
				end
			end
			r.wide_converter = wide;
			awaited_res.push_back(r);
		endfunction

		function void cmp(string field, logic signed [63:0] want, logic signed [63:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t: %s expected %0d actual %0d", $time, field, want, got);
			end
		endfunction

		function void check_res(res_t a);
			res_t e;
			if (awaited_res.size() == 0) begin
				errors++;
				$display("%0t: result with none awaited: expected none actual %h", $time, a);
				return;
			end
			e = awaited_res.pop_front();
			cmp("set_channel", e.set_channel, a.set_channel);
			cmp("set_gain", e.set_gain, a.set_gain);
			cmp("conversion_wanted", e.conversion_wanted, a.conversion_wanted);
			cmp("reading_valid", e.reading_valid, a.reading_valid);
			cmp("reading_channel", e.reading_channel, a.reading_channel);
			cmp("reading_gain", e.reading_gain, a.reading_gain);
			cmp("reading_code", e.reading_code, a.reading_code);
			cmp("reading_microvolts", e.reading_microvolts, a.reading_microvolts);
			cmp("wide_converter", e.wide_converter, a.wide_converter);
			cmp("sweep_done", e.sweep_done, a.sweep_done);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	cmd_t cmd = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	autorange_tracker sweep = new();

	adc_autorange_gain_sweep DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			sweep.check_res(res);
		res_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	task automatic send(cmd_t c);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd <= c;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		sweep.take_cmd(c);
	endtask

	task automatic start_sweep();
		cmd_t c;
		c.func = FUNC_START;
		c.sample_bytes = 16'($urandom);
		send(c);
	endtask

	// raw is the code in natural order; the bus carries it byte-swapped
	task automatic convert(logic [15:0] raw);
		cmd_t c;
		c.func = FUNC_CONVERT;
		c.sample_bytes = {raw[7:0], raw[15:8]};
		send(c);
	endtask

	task automatic drain();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (sweep.awaited_res.size() != 0)
			@(posedge clk);
	endtask

	task automatic random_phase(int n);
		int          done_items;
		logic [15:0] raw;
		bit          hot;
		done_items = 0;
		hot = 1'b0;
		while (done_items < n) begin
			if (!sweep.active) begin
				if ($urandom_range(99) < 85) begin
					start_sweep();
					done_items++;
				end else begin
					// leaves the sweep state unchanged; does not count
					convert(16'($urandom));
				end
			end else if ($urandom_range(99) < 3) begin
				start_sweep();
				done_items++;
			end else begin
				// some channels keep clipping so the gain walks all the way down
				if (sweep.gain == GAIN_WIDEST)
					hot = ($urandom_range(99) < 20);
				if ($urandom_range(99) < (hot ? 90 : 25)) begin
					case ($urandom_range(2))
						0:       raw = FS_WIDE;
						1:       raw = FS_NARROW;
						default: raw = CODE_MIN;
					endcase
				end else if ($urandom_range(99) < 15) begin
					case ($urandom_range(5))
						0:       raw = 16'h7ffe;
						1:       raw = 16'h8001;
						2:       raw = 16'h0000;
						3:       raw = 16'hffff;
						4:       raw = 16'h0001;
						default: raw = 16'hfff0;
					endcase
				end else begin
					raw = 16'($urandom);
				end
				convert(raw);
				done_items++;
			end
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: idle conversion, gain walk to 0 with narrow codes, wide detect,
		// restart mid-sweep, full sweep to completion, idle conversion after it
		send_idle_pct = 30;
		recv_idle_pct = 45;
		convert(16'h1234);
		start_sweep();
		convert(FS_NARROW);
		convert(CODE_MIN);
		convert(FS_NARROW);
		convert(FS_NARROW);
		convert(CODE_MIN);
		convert(FS_NARROW);
		convert(FS_NARROW);
		convert(CODE_MIN);
		convert(FS_NARROW);
		convert(16'h0001);
		convert(FS_WIDE);
		convert(16'hffff);
		convert(16'h0000);
		convert(FS_NARROW);
		start_sweep();
		convert(16'h7ffe);
		convert(16'h8001);
		convert(16'h5a5a);
		convert(16'ha5a5);
		convert(16'h0010);
		convert(16'hfff0);
		convert(16'h4000);
		convert(16'hc000);
		convert(16'hbeef);
		drain();

		random_phase(RANDOM_ITEMS / 3);
		drain();
		send_idle_pct = 45;
		recv_idle_pct = 30;
		random_phase(RANDOM_ITEMS / 3);
		drain();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_phase(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
		drain();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sweep.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
